/* rtl/lrts_pkg.sv */
`default_nettype none
package lrts_pkg;

   localparam int NUM_SLOTS  = 8;
   localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   // wide enough for any 3-bit slot number and for NUM_SLOTS itself
   localparam int SLOT_EXT_W = 7;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic        mode;
      logic [2:0]  slot;
      logic [15:0] job_id;
      logic [15:0] arrival;
      logic [7:0]  burst;
   } req_type;

   typedef struct packed {
      logic        ran;
      logic [2:0]  ran_slot;
      logic [15:0] ran_id;
      logic        finished;
      logic [15:0] finish_time;
      logic        all_done;
   } rsp_type;

   // best candidate so far, handed from cell to cell
   typedef struct packed {
      logic        found;
      logic [7:0]  work;
      idx_type     idx;
      logic [15:0] id;
   } cand_type;

   typedef struct packed {
      logic        en;
      idx_type     idx;
      logic [15:0] id;
      logic [15:0] arrival;
      logic [7:0]  burst;
   } wr_type;

   typedef struct packed {
      logic    en;
      idx_type idx;
   } dec_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_REPORT = 4'b1000
   } state_type;

endpackage
`default_nettype wire

/* rtl/lrts_cell.sv */
`default_nettype none
module lrts_cell (
   input  wire                logic       clock,
   input  wire                logic       reset,
   input  lrts_pkg::idx_type              cell_idx,
   input  lrts_pkg::wr_type               wr,
   input  lrts_pkg::dec_type              dec,
   input  wire                logic [15:0] cur_time,
   input  lrts_pkg::cand_type             cand_in,
   output lrts_pkg::cand_type             cand_out,
   output logic                           nonzero
);

   logic [7:0]         work_ff, work_in;
   logic [15:0]        arrival_ff, arrival_in;
   logic [15:0]        id_ff, id_in;
   lrts_pkg::cand_type cand_ff, cand_in_nxt;
   logic               eligible;
   logic               take;

   assign nonzero  = (work_ff != 8'd0);
   assign eligible = nonzero && (arrival_ff <= cur_time);
   // strictly greater: an earlier cell keeps a tie
   assign take     = eligible && (!cand_in.found || (work_ff > cand_in.work));

   always_comb begin
      work_in    = work_ff;
      arrival_in = arrival_ff;
      id_in      = id_ff;
      if (wr.en && (wr.idx == cell_idx)) begin
         work_in    = wr.burst;
         arrival_in = wr.arrival;
         id_in      = wr.id;
      end else if (dec.en && (dec.idx == cell_idx)) begin
         work_in = work_ff - 8'd1;
      end
   end

   always_comb begin
      cand_in_nxt = cand_in;
      if (take) begin
         cand_in_nxt.found = 1'b1;
         cand_in_nxt.work  = work_ff;
         cand_in_nxt.idx   = cell_idx;
         cand_in_nxt.id    = id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff       <= 8'd0;
         cand_ff.found <= 1'b0;
      end else begin
         work_ff       <= work_in;
         cand_ff.found <= cand_in_nxt.found;
      end
      arrival_ff   <= arrival_in;
      id_ff        <= id_in;
      cand_ff.work <= cand_in_nxt.work;
      cand_ff.idx  <= cand_in_nxt.idx;
      cand_ff.id   <= cand_in_nxt.id;
   end

   assign cand_out = cand_ff;

endmodule
`default_nettype wire

/* rtl/longest_remaining_time_scheduler.sv */
// Load request: result in the cycle after acceptance; a next request is taken once
// idle again. Tick request: the best candidate walks the row of slot cells one cell
// per cycle in the scan state, then the commit state applies the decrement and the
// report state shows the result. One request at a time, busy until done.
// Results are strobed for one cycle on rsp_valid; the receiver cannot stall.
// Synchronous reset empties every slot, zeroes time and returns to idle.
`default_nettype none
module longest_remaining_time_scheduler (
   input  wire              logic clock,
   input  wire              logic reset,
   input  wire              logic start,
   output logic                   busy,
   input  lrts_pkg::req_type      req_data,
   output logic                   rsp_valid,
   output lrts_pkg::rsp_type      rsp_data
);

   lrts_pkg::state_type state_ff, state_in;
   lrts_pkg::idx_type   cnt_ff, cnt_in;
   logic [15:0]         time_ff, time_in;
   logic                ran_ff, ran_in;
   logic [2:0]          slot_ff, slot_in;
   logic [15:0]         id_ff, id_in;
   logic                fin_ff, fin_in;

   lrts_pkg::cand_type  chain [lrts_pkg::NUM_SLOTS+1];
   logic [lrts_pkg::NUM_SLOTS-1:0] nz;
   lrts_pkg::wr_type    wr;
   lrts_pkg::dec_type   dec;
   lrts_pkg::cand_type  best;
   logic                accept;
   logic                load_ok;

   assign accept  = start && (state_ff == lrts_pkg::ST_IDLE);
   assign load_ok = (lrts_pkg::SLOT_EXT_W'(req_data.slot)
                     < lrts_pkg::SLOT_EXT_W'(lrts_pkg::NUM_SLOTS));
   assign best    = chain[lrts_pkg::NUM_SLOTS];

   assign wr.en      = accept && (req_data.mode == lrts_pkg::MODE_LOAD) && load_ok;
   assign wr.idx     = lrts_pkg::IDX_W'(req_data.slot);
   assign wr.id      = req_data.job_id;
   assign wr.arrival = req_data.arrival;
   assign wr.burst   = req_data.burst;

   assign dec.en  = (state_ff == lrts_pkg::ST_COMMIT) && best.found;
   assign dec.idx = best.idx;

   assign chain[0] = '0;

   for (genvar g = 0; g < lrts_pkg::NUM_SLOTS; g++) begin : g_cell
      lrts_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (lrts_pkg::IDX_W'(g)),
         .wr       (wr),
         .dec      (dec),
         .cur_time (time_ff),
         .cand_in  (chain[g]),
         .cand_out (chain[g+1]),
         .nonzero  (nz[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      time_in  = time_ff;
      ran_in   = ran_ff;
      slot_in  = slot_ff;
      id_in    = id_ff;
      fin_in   = fin_ff;
      unique case (state_ff)
         lrts_pkg::ST_IDLE: begin
            if (start) begin
               ran_in  = 1'b0;
               slot_in = 3'd0;
               id_in   = 16'd0;
               fin_in  = 1'b0;
               cnt_in  = '0;
               if (req_data.mode == lrts_pkg::MODE_TICK) begin
                  state_in = lrts_pkg::ST_SCAN;
               end else begin
                  state_in = lrts_pkg::ST_REPORT;
               end
            end
         end
         lrts_pkg::ST_SCAN: begin
            // chain settles one cell per cycle while slot state stands still
            if (cnt_ff == lrts_pkg::IDX_W'(lrts_pkg::NUM_SLOTS - 1)) begin
               state_in = lrts_pkg::ST_COMMIT;
            end else begin
               cnt_in = cnt_ff + lrts_pkg::IDX_W'(1);
            end
         end
         lrts_pkg::ST_COMMIT: begin
            time_in = time_ff + 16'd1;
            if (best.found) begin
               ran_in  = 1'b1;
               slot_in = 3'(best.idx);
               id_in   = best.id;
               fin_in  = (best.work == 8'd1);
            end
            state_in = lrts_pkg::ST_REPORT;
         end
         lrts_pkg::ST_REPORT: begin
            state_in = lrts_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrts_pkg::ST_IDLE;
         cnt_ff   <= '0;
         time_ff  <= 16'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         time_ff  <= time_in;
      end
      ran_ff  <= ran_in;
      slot_ff <= slot_in;
      id_ff   <= id_in;
      fin_ff  <= fin_in;
   end

   assign busy      = (state_ff != lrts_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == lrts_pkg::ST_REPORT);

   always_comb begin
      rsp_data.ran         = ran_ff;
      rsp_data.ran_slot    = slot_ff;
      rsp_data.ran_id      = id_ff;
      rsp_data.finished    = fin_ff;
      rsp_data.finish_time = time_ff;
      rsp_data.all_done    = ~|nz;
   end

endmodule
`default_nettype wire

/* rtl/lrts_checker.sv */
`default_nettype none
module lrts_checker (
   input wire               logic clock,
   input wire               logic reset,
   input wire               logic start,
   input wire               logic busy,
   input lrts_pkg::req_type       req_data,
   input wire               logic rsp_valid,
   input lrts_pkg::rsp_type       rsp_data
);

   // a taken request raises busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown with no request in progress");

   a_finish_needs_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.finished) |-> rsp_data.ran)
      else $error("completion reported without a job running");

   a_idle_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ran) |-> (rsp_data.ran_id == 16'd0
                                        && rsp_data.ran_slot == 3'd0))
      else $error("idle or load result carries a job");

endmodule

bind longest_remaining_time_scheduler lrts_checker u_lrts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

/* dv/lrts_choice_checker.sv */
`default_nettype none
module lrts_choice_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic          busy,
   input  lrts_pkg::req_type  req_data,
   input  wire logic          rsp_valid,
   input  lrts_pkg::rsp_type  rsp_data,
   output int                 fail_count,
   output int                 outstanding
);

   logic [7:0]  work_left  [lrts_pkg::NUM_SLOTS];
   logic [15:0] arrives_at [lrts_pkg::NUM_SLOTS];
   logic [15:0] ident      [lrts_pkg::NUM_SLOTS];
   logic [15:0] now;
   lrts_pkg::rsp_type expected_q [$];
   int          mismatches = 0;

   task automatic clear_table();
      foreach (work_left[k]) begin
         work_left[k]  = '0;
         arrives_at[k] = '0;
         ident[k]      = '0;
      end
      now = '0;
   endtask

   // applies one request to the local copy of the slot table
   task automatic schedule_request(input lrts_pkg::req_type r,
                                   output lrts_pkg::rsp_type res);
      int best;
      logic none_left;
      res  = '0;
      best = -1;
      if (r.mode == lrts_pkg::MODE_LOAD) begin
         if (int'(r.slot) < lrts_pkg::NUM_SLOTS) begin
            ident[r.slot]      = r.job_id;
            arrives_at[r.slot] = r.arrival;
            work_left[r.slot]  = r.burst;
         end
      end else begin
         // strict greater-than keeps ties on the lowest slot
         for (int k = 0; k < lrts_pkg::NUM_SLOTS; k++)
            if (work_left[k] != 0 && arrives_at[k] <= now &&
                (best < 0 || work_left[k] > work_left[best]))
               best = k;
         now = now + 16'd1;
         if (best >= 0) begin
            work_left[best] = work_left[best] - 8'd1;
            res.ran         = 1'b1;
            res.ran_slot    = 3'(best);
            res.ran_id      = ident[best];
            res.finished    = (work_left[best] == 8'd0);
         end
      end
      res.finish_time = now;
      none_left = 1'b1;
      foreach (work_left[k])
         if (work_left[k] != 0)
            none_left = 1'b0;
      res.all_done = none_left;
   endtask

   task automatic note_mismatch(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
   endtask

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want)
         note_mismatch(what, want, got);
   endtask

   always @(posedge clock) begin
      lrts_pkg::rsp_type want;
      lrts_pkg::rsp_type res;
      if (reset) begin
         clear_table();
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               note_mismatch("unrequested result", 16'h0, rsp_data.finish_time);
            end else begin
               want = expected_q.pop_front();
               check_field("ran",         16'(want.ran),      16'(rsp_data.ran));
               check_field("ran_slot",    16'(want.ran_slot), 16'(rsp_data.ran_slot));
               check_field("ran_id",      want.ran_id,        rsp_data.ran_id);
               check_field("finished",    16'(want.finished), 16'(rsp_data.finished));
               check_field("finish_time", want.finish_time,   rsp_data.finish_time);
               check_field("all_done",    16'(want.all_done), 16'(rsp_data.all_done));
            end
         end
         if (start && !busy) begin
            schedule_request(req_data, res);
            expected_q.push_back(res);
         end
      end
      outstanding <= expected_q.size();
      fail_count  <= mismatches;
   end

endmodule
`default_nettype wire

/* dv/longest_remaining_time_scheduler_test.sv */
`default_nettype none
module longest_remaining_time_scheduler_test;

   localparam int STALL_LIMIT = 1000;
   localparam int RANDOM_ITEMS = 1900;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              rsp_valid;
   lrts_pkg::req_type req_data;
   lrts_pkg::rsp_type rsp_data;
   int                fail_count;
   int                outstanding;

   logic [15:0] tick_count = '0;
   int          sent = 0;
   int          calm_left = 0;

   longest_remaining_time_scheduler DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   lrts_choice_checker choice_chk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly back to back, some short gaps, a few long ones, and calm stretches
   function automatic int gap_len();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(25, 80);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic issue(input lrts_pkg::req_type r);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (r.mode == lrts_pkg::MODE_TICK)
         tick_count++;
      sent++;
      @(negedge clock);
   endtask

   task automatic send_load(input logic [2:0] s, input logic [15:0] id,
                            input logic [15:0] arr, input logic [7:0] b);
      lrts_pkg::req_type r;
      r.mode    = lrts_pkg::MODE_LOAD;
      r.slot    = s;
      r.job_id  = id;
      r.arrival = arr;
      r.burst   = b;
      issue(r);
   endtask

   // the other fields are don't-care on a tick, so they carry noise
   task automatic send_tick();
      lrts_pkg::req_type r;
      r.mode    = lrts_pkg::MODE_TICK;
      r.slot    = 3'($urandom);
      r.job_id  = 16'($urandom);
      r.arrival = 16'($urandom);
      r.burst   = 8'($urandom);
      issue(r);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid)
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      int          r;
      int          goal;
      int          mid;
      bit          mid_done;
      logic [15:0] arr;
      logic [7:0]  b;

      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty table, future arrival, ties, overwrite, clear
      send_tick();
      send_load(3'd0, 16'h0000, 16'h0000, 8'd0);
      send_load(3'd7, 16'hFFFF, 16'hFFFF, 8'd255);
      send_tick();
      send_load(3'd1, 16'h1234, 16'h0000, 8'd2);
      send_load(3'd2, 16'h5678, 16'h0000, 8'd2);
      repeat (4) send_tick();
      send_load(3'd3, 16'hA5A5, 16'h0000, 8'd1);
      send_load(3'd3, 16'h5A5A, 16'h0000, 8'd3);
      send_tick();
      send_load(3'd3, 16'h0F0F, 16'h0000, 8'd0);
      send_tick();
      send_load(3'd7, 16'h0000, 16'h0000, 8'd0);
      send_load(3'd4, 16'hC3C3, tick_count + 16'd2, 8'd1);
      repeat (3) send_tick();
      send_load(3'd5, 16'h00FF, 16'h0000, 8'd1);
      send_load(3'd6, 16'hFF00, 16'h0000, 8'd1);
      repeat (2) send_tick();

      // random: mostly ticks, loads near current time, occasional table clear
      goal     = sent + RANDOM_ITEMS;
      mid      = sent + RANDOM_ITEMS / 2;
      mid_done = 1'b0;
      while (sent < goal) begin
         if (!mid_done && sent >= mid) begin
            drain();
            repeat ($urandom_range(1, 20)) @(negedge clock);
            mid_done = 1'b1;
         end
         r = $urandom_range(0, 99);
         if (r < 4) begin
            for (int s = 0; s < 8; s++)
               send_load(3'(s), 16'($urandom), 16'($urandom), 8'd0);
         end else if (r < 44) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               arr = tick_count + 16'($urandom_range(0, 6));
            else if (r < 85)
               arr = tick_count - 16'($urandom_range(0, 50));
            else
               arr = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 70)
               b = 8'($urandom_range(1, 8));
            else if (r < 82)
               b = 8'd0;
            else if (r < 86)
               b = 8'($urandom_range(200, 255));
            else
               b = 8'($urandom);
            send_load(3'($urandom_range(0, 7)), 16'($urandom), arr, b);
         end else begin
            send_tick();
         end
      end

      // jobs due at the very top of the time range stay out of the choice
      drain();
      send_load(3'd7, 16'hBEEF, 16'hFFFF, 8'd255);
      send_load(3'd6, 16'h8001, 16'hFFFE, 8'd2);
      repeat (8) send_tick();

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
rtl/lrts_pkg.sv
rtl/lrts_cell.sv
rtl/longest_remaining_time_scheduler.sv
rtl/lrts_checker.sv
dv/lrts_choice_checker.sv
dv/longest_remaining_time_scheduler_test.sv
